>>> rtl/core/dbdd_pkg.sv
// Shared types and constants for the two-beam direction detector.
// Holds the sample and result word layouts, the pair codes and the register map.
// No dependencies.
`default_nettype none

package dbdd_pkg;

	localparam int SAMPLE_W  = 10;
	localparam int EVENT_W   = 2;
	localparam int CODE_W    = 2;
	localparam int FILL_W    = 2;
	localparam int APB_DW    = 32;
	localparam int APB_AW    = 2;

	localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = SAMPLE_W'(70);

	// register map (byte addresses)
	localparam logic [APB_AW-1:0] REG_THRESHOLD = APB_AW'(0);

	// beam pair codes
	localparam logic [CODE_W-1:0] CODE_DARK   = 2'd0;
	localparam logic [CODE_W-1:0] CODE_B_ONLY = 2'd1;
	localparam logic [CODE_W-1:0] CODE_A_ONLY = 2'd2;
	localparam logic [CODE_W-1:0] CODE_IDLE   = 2'd3;

	// crossing events
	localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
	localparam logic [EVENT_W-1:0] EV_ENTRY = 2'd1;
	localparam logic [EVENT_W-1:0] EV_EXIT  = 2'd2;

	localparam logic [FILL_W-1:0] FILL_EMPTY = 2'd0;
	localparam logic [FILL_W-1:0] FILL_ONE   = 2'd1;
	localparam logic [FILL_W-1:0] FILL_TWO   = 2'd2;
	localparam logic [FILL_W-1:0] FILL_FULL  = 2'd3;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_a;
		logic [SAMPLE_W-1:0] sample_b;
	} sample_t;

	typedef struct packed {
		logic [EVENT_W-1:0] event_res;
		logic               lamp_a;
		logic               lamp_b;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/core/dual_beam_direction_detector.sv
// Pipeline: a word accepted is registered in stage 1, and its result is registered
// in stage 2, the result register, when stage 1 advances, and is offered from there.
// Throughput: one sample pair per cycle while result_ready does not stall stage 2;
// the crossing history updates as a word moves from stage 1 into the result register.
// Reset: arst_n clears the history, both valid flags and sets threshold to 70.
// Depends on dbdd_pkg.
`default_nettype none

module dual_beam_direction_detector (
	input  wire                            clk,
	input  wire                            arst_n,
	// configuration port
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire  [dbdd_pkg::APB_AW-1:0]    paddr,
	input  wire  [dbdd_pkg::APB_DW-1:0]    pwdata,
	output logic [dbdd_pkg::APB_DW-1:0]    prdata,
	output logic                           pready,
	// sample channel
	input  wire                            sample_valid,
	output logic                           sample_ready,
	input  dbdd_pkg::sample_t              sample,
	// result channel
	output logic                           result_valid,
	input  wire                            result_ready,
	output dbdd_pkg::result_t              result
);
	import dbdd_pkg::*;

	logic [SAMPLE_W-1:0] threshold_q;

	sample_t             sample_s1;
	logic                valid_s1;
	result_t             result_s2;
	logic                valid_s2;

	logic [CODE_W-1:0]   hist0_q, hist1_q, hist2_q;
	logic [FILL_W-1:0]   fill_q;

	logic [CODE_W-1:0]   hist0_d, hist1_d, hist2_d;
	logic [FILL_W-1:0]   fill_d;
	logic [EVENT_W-1:0]  event_d;
	logic                lit_a, lit_b;
	logic [CODE_W-1:0]   code;
	logic [CODE_W-1:0]   newest, prior;
	logic                adv_s1;
	logic                cfg_wr;

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == REG_THRESHOLD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_wr) begin
			threshold_q <= pwdata[SAMPLE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == REG_THRESHOLD) begin
			prdata = APB_DW'(threshold_q);
		end
	end

	// ---------------- handshake ----------------
	assign adv_s1       = valid_s1 && (!valid_s2 || result_ready);
	assign sample_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (sample_ready) begin
				valid_s1 <= sample_valid;
			end
			if (!valid_s2 || result_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			sample_s1 <= sample;
		end
		if (adv_s1) begin
			result_s2 <= '{event_res: event_d, lamp_a: lit_a, lamp_b: lit_b};
		end
	end

	// ---------------- crossing tracker ----------------
	// sample equal to threshold counts as dark
	assign lit_a = sample_s1.sample_a < threshold_q;
	assign lit_b = sample_s1.sample_b < threshold_q;
	assign code  = {lit_a, lit_b};

	always_comb begin
		unique case (fill_q)
			FILL_ONE: newest = hist0_q;
			FILL_TWO: newest = hist1_q;
			default:  newest = hist2_q;
		endcase
		prior = (fill_q == FILL_TWO) ? hist0_q : hist1_q;
	end

	always_comb begin
		hist0_d = hist0_q;
		hist1_d = hist1_q;
		hist2_d = hist2_q;
		fill_d  = fill_q;
		event_d = EV_NONE;
		if (fill_q == FILL_EMPTY) begin
			if (code != CODE_IDLE) begin
				hist0_d = code;
				fill_d  = FILL_ONE;
			end
		end else if (newest == code) begin
			// repeat: nothing changes
		end else if (code == CODE_IDLE) begin
			if (fill_q == FILL_FULL) begin
				if (hist2_q == CODE_A_ONLY) begin
					event_d = EV_ENTRY;
				end else if (hist2_q == CODE_B_ONLY) begin
					event_d = EV_EXIT;
				end
			end
			fill_d = FILL_EMPTY;
		end else if (fill_q != FILL_ONE && prior == code) begin
			// back-step: ignored
		end else if (fill_q == FILL_FULL && hist0_q == code) begin
			// re-seed from the first code
			hist1_d = code;
			fill_d  = FILL_TWO;
		end else if (fill_q == FILL_ONE) begin
			hist1_d = code;
			fill_d  = FILL_TWO;
		end else if (fill_q == FILL_TWO) begin
			hist2_d = code;
			fill_d  = FILL_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist0_q <= CODE_DARK;
			hist1_q <= CODE_DARK;
			hist2_q <= CODE_DARK;
			fill_q  <= FILL_EMPTY;
		end else if (adv_s1) begin
			hist0_q <= hist0_d;
			hist1_q <= hist1_d;
			hist2_q <= hist2_d;
			fill_q  <= fill_d;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// ---------------- assertions ----------------
	a_no_bad_event: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.event_res != 2'd3))
		else $error("reserved event code on result");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> sample_ready)
		else $error("input stalled with empty result register");

	a_event_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && event_d != EV_NONE) |-> (fill_q == FILL_FULL))
		else $error("crossing reported without three codes");

	a_event_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && event_d != EV_NONE) |=> (fill_q == FILL_EMPTY))
		else $error("history kept after crossing");

	a_first_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != FILL_EMPTY) |-> (hist0_q != CODE_IDLE))
		else $error("idle code stored as first entry");

endmodule

`default_nettype wire
